>>> src/rssa_pkg.sv
// Package for the random-start slot allocator.
// Holds the beat structs, command/status structs, operation codes and defaults.
// No dependencies.
package rssa_pkg;

  localparam int SLOT_COUNT_DEF  = 64;
  localparam int STACK_DEPTH_DEF = 64;

  // slots examined per search cycle (power of two)
  localparam int GROUP_W = 8;

  localparam logic [2:0] KIND_ALLOC     = 3'd0;
  localparam logic [2:0] KIND_REINSTATE = 3'd1;
  localparam logic [2:0] KIND_PUSH      = 3'd2;
  localparam logic [2:0] KIND_FLUSH     = 3'd3;
  localparam logic [2:0] KIND_CLEAR     = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] random_byte;
    logic [7:0] number;
    logic [6:0] pop_count;
  } in_item_t;

  typedef struct packed {
    logic [6:0] granted_number;
    logic       success;
    logic       error_flag;
    logic [6:0] free_count;
    logic [6:0] stack_count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic seed;
    logic search;
    logic reinst;
    logic push;
    logic flush_init;
    logic flush_rd;
    logic flush_apply;
    logic clear;
    logic result_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       free_zero;
    logic       hit;
    logic       rem_zero;
  } dp_stat_t;

endpackage

>>> src/random_start_slot_allocator.sv
// Random-start slot allocator. One item in flight; result beat held in an output register.
// Each item is decoded, then finished; allocate with a free number first scans 8-slot groups
// (start group seen twice, from the start slot up, then in full after the wrap-around), and
// flush first reads and applies the popped entries one by one. Result registered on finish.
// A new item is taken the cycle after the result is registered, even if it is not yet taken.
// Synchronous active-low reset: all numbers free, stack empty, no result pending.
module random_start_slot_allocator #(
  parameter int SLOT_COUNT  = rssa_pkg::SLOT_COUNT_DEF,
  parameter int STACK_DEPTH = rssa_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rssa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rssa_pkg::out_item_t out_data
);

  rssa_pkg::dp_cmd_t  cmd;
  rssa_pkg::dp_stat_t stat;

  rssa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rssa_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .out_data(out_data)
  );

endmodule

>>> src/rssa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rssa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/rssa_dp.sv
// Datapath: used map, free and stack counters, group search, stack RAM, result register.
// Depends on rssa_pkg and rssa_ram.
module rssa_dp #(
  parameter int SLOT_COUNT  = rssa_pkg::SLOT_COUNT_DEF,
  parameter int STACK_DEPTH = rssa_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rssa_pkg::in_item_t  in_data,
  input  rssa_pkg::dp_cmd_t   cmd,
  output rssa_pkg::dp_stat_t  stat,
  output rssa_pkg::out_item_t out_data
);

  localparam int CELL_W  = $clog2(SLOT_COUNT);
  localparam int FREE_W  = $clog2(SLOT_COUNT + 1);
  localparam int SP_W    = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int GW      = rssa_pkg::GROUP_W;
  localparam int GOFF_W  = $clog2(GW);
  localparam int NGROUPS = (SLOT_COUNT + GW - 1) / GW;
  localparam int GI_W    = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int PAD     = NGROUPS * GW;
  localparam int POS_W   = GI_W + GOFF_W;
  localparam int CW      = (SP_W > 7) ? SP_W : 7;
  localparam int MOD_W   = 16;

  rssa_pkg::in_item_t  item_r;
  rssa_pkg::out_item_t out_r;
  logic [SLOT_COUNT-1:0] used_r;
  logic [FREE_W-1:0]    free_r;
  logic [SP_W-1:0]      sp_r;
  logic [SP_W-1:0]      rem_r;
  logic [GI_W-1:0]      grp_r;
  logic [GOFF_W-1:0]    off_r;
  logic                 first_r;
  logic [6:0]           granted_r;
  logic                 success_r;
  logic                 err_r;

  // start slot: random byte reduced by restoring subtraction
  logic [MOD_W-1:0] mod_acc;
  logic [POS_W-1:0] start_pos;

  always_comb begin
    mod_acc = MOD_W'(item_r.random_byte);
    for (int k = 7; k >= 0; k--) begin
      if (mod_acc >= (MOD_W'(SLOT_COUNT) << k)) begin
        mod_acc = mod_acc - (MOD_W'(SLOT_COUNT) << k);
      end
    end
  end

  assign start_pos = POS_W'(mod_acc);

  // one group of the map per cycle; padding reads as used
  logic [PAD-1:0]    used_pad;
  logic [GW-1:0]     grp_bits;
  logic [GW-1:0]     grp_mask;
  logic [GW-1:0]     cand;
  logic              hit;
  logic [GOFF_W-1:0] hit_idx;
  logic [POS_W-1:0]  hit_pos;
  logic [CELL_W-1:0] hit_slot;
  logic [CELL_W:0]   hit_num;
  logic [GI_W-1:0]   grp_next;

  always_comb begin
    used_pad = '1;
    used_pad[SLOT_COUNT-1:0] = used_r;
  end

  assign grp_bits = used_pad[grp_r*GW +: GW];
  // first visit skips slots below the start; the wrap-around visit sees them
  assign grp_mask = first_r ? ({GW{1'b1}} << off_r) : {GW{1'b1}};
  assign cand     = ~grp_bits & grp_mask;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int j = GW - 1; j >= 0; j--) begin
      if (cand[j]) begin
        hit     = 1'b1;
        hit_idx = GOFF_W'(j);
      end
    end
  end

  assign hit_pos  = {grp_r, hit_idx};
  assign hit_slot = CELL_W'(hit_pos);
  assign hit_num  = {1'b0, hit_slot} + 1'b1;
  assign grp_next = (grp_r == GI_W'(NGROUPS - 1)) ? '0 : grp_r + 1'b1;

  // shared reinstate path: item number or popped stack entry
  logic [7:0]        ram_rdata;
  logic [7:0]        rin_num;
  logic              rin_ok;
  logic [CELL_W-1:0] rin_slot;
  logic              rin_hit;
  logic              push_ok;

  assign rin_num  = cmd.flush_apply ? ram_rdata : item_r.number;
  assign rin_ok   = (rin_num != 8'd0) && (9'(rin_num) <= 9'(SLOT_COUNT));
  assign rin_slot = CELL_W'(rin_num - 8'd1);
  assign rin_hit  = rin_ok && used_r[rin_slot];
  assign push_ok  = rin_ok && (sp_r < SP_W'(STACK_DEPTH));

  logic [SP_W-1:0] flush_clamp;
  assign flush_clamp = (CW'(item_r.pop_count) > CW'(sp_r)) ? sp_r
                                                          : SP_W'(item_r.pop_count);

  rssa_ram #(
    .WIDTH(8),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (cmd.push && push_ok),
    .waddr(ADDR_W'(sp_r)),
    .wdata(item_r.number),
    .re   (cmd.flush_rd),
    .raddr(ADDR_W'(sp_r - 1'b1)),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      free_r <= FREE_W'(SLOT_COUNT);
      sp_r   <= '0;
    end else begin
      if (cmd.clear) begin
        used_r <= '0;
        free_r <= FREE_W'(SLOT_COUNT);
        sp_r   <= '0;
      end
      if (cmd.search && hit) begin
        used_r[hit_slot] <= 1'b1;
        free_r           <= free_r - 1'b1;
      end
      if ((cmd.reinst || cmd.flush_apply) && rin_hit) begin
        used_r[rin_slot] <= 1'b0;
        free_r           <= free_r + 1'b1;
      end
      if (cmd.push && push_ok) begin
        sp_r <= sp_r + 1'b1;
      end
      if (cmd.flush_rd) begin
        sp_r <= sp_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r    <= in_data;
      granted_r <= '0;
      success_r <= 1'b0;
      err_r     <= 1'b0;
    end
    if (cmd.seed) begin
      grp_r   <= start_pos[POS_W-1:GOFF_W];
      off_r   <= start_pos[GOFF_W-1:0];
      first_r <= 1'b1;
    end
    if (cmd.search) begin
      if (hit) begin
        granted_r <= 7'(hit_num);
      end else begin
        grp_r   <= grp_next;
        first_r <= 1'b0;
      end
    end
    if (cmd.reinst) begin
      success_r <= rin_hit;
      err_r     <= !rin_ok;
    end
    if (cmd.push) begin
      success_r <= push_ok;
      err_r     <= !push_ok;
    end
    if (cmd.flush_init) begin
      rem_r     <= flush_clamp;
      success_r <= 1'b1;
    end
    if (cmd.flush_rd) begin
      rem_r <= rem_r - 1'b1;
    end
    if (cmd.clear) begin
      success_r <= 1'b1;
    end
    if (cmd.result_load) begin
      out_r.granted_number <= granted_r;
      out_r.success        <= success_r;
      out_r.error_flag     <= err_r;
      out_r.free_count     <= 7'(free_r);
      out_r.stack_count    <= 7'(sp_r);
    end
  end

  assign stat.kind      = item_r.kind;
  assign stat.free_zero = (free_r == '0);
  assign stat.hit       = hit;
  assign stat.rem_zero  = (rem_r == '0);
  assign out_data       = out_r;

endmodule

>>> src/rssa_ctrl.sv
// Controller: sequences one item at a time through the datapath and owns the handshakes.
// Depends on rssa_pkg.
module rssa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rssa_pkg::dp_stat_t stat,
  output rssa_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_FLUSH_RD,
    S_FLUSH_AP,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.kind)
          rssa_pkg::KIND_ALLOC: begin
            if (stat.free_zero) begin
              state_nxt = S_FINISH;
            end else begin
              cmd.seed  = 1'b1;
              state_nxt = S_SEARCH;
            end
          end
          rssa_pkg::KIND_REINSTATE: begin
            cmd.reinst = 1'b1;
            state_nxt  = S_FINISH;
          end
          rssa_pkg::KIND_PUSH: begin
            cmd.push  = 1'b1;
            state_nxt = S_FINISH;
          end
          rssa_pkg::KIND_FLUSH: begin
            cmd.flush_init = 1'b1;
            state_nxt      = S_FLUSH_RD;
          end
          rssa_pkg::KIND_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_FINISH;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_SEARCH: begin
        // a free slot exists, so the walk always ends in a hit
        cmd.search = 1'b1;
        if (stat.hit) begin
          state_nxt = S_FINISH;
        end
      end
      S_FLUSH_RD: begin
        if (stat.rem_zero) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.flush_rd = 1'b1;
          state_nxt    = S_FLUSH_AP;
        end
      end
      S_FLUSH_AP: begin
        // apply the entry read last cycle, fetch the next behind it while entries remain
        cmd.flush_apply = 1'b1;
        if (stat.rem_zero) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.flush_rd = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.result_load = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.result_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> src/rssa_chk.sv
// Port-level checks for the random-start slot allocator, bound to the top level.
// Depends on rssa_pkg and random_start_slot_allocator.
module rssa_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input rssa_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input rssa_pkg::out_item_t out_data
);

  // stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input beat changed while stalled");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  // a grant only comes from allocate, which carries no flags
  a_grant_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.granted_number != 7'd0 |->
      !out_data.success && !out_data.error_flag)
    else $error("granted number with status flags set");

  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.success && out_data.error_flag))
    else $error("success and error both set");

endmodule

bind random_start_slot_allocator rssa_chk u_rssa_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

>>> test/testbench.sv
// Self-checking testbench for random_start_slot_allocator.
// Holds its own model of the slot map and number stack, a burst-mode driver and a monitor.
// Depends on rssa_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module testbench;

  localparam int CELLS = rssa_pkg::SLOT_COUNT_DEF;
  localparam int DEPTH = rssa_pkg::STACK_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_TARGET = 800;
  localparam int DRAIN_CYCLES = 100;
  // highest encodable kind; everything above KIND_CLEAR is ignored by the block
  localparam logic [2:0] KIND_TOP = 3'd7;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  rssa_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rssa_pkg::out_item_t out_data;

  random_start_slot_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // model state
  bit slot_used [CELLS];
  int free_left;
  int held [DEPTH];
  int held_depth;

  rssa_pkg::in_item_t  cmd_backlog[$];
  rssa_pkg::out_item_t awaited_outcomes[$];
  int                  errors = 0;
  int                  cycles = 0;
  logic                in_took = 1'b0;

  // sender burst / gap state, receiver stall state
  int burst_left = 0;
  int gap_left = 0;
  int ready_mode = 0;
  int ready_phase_left = 0;
  int ready_tick = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit release_number(int n);
    if (n < 1 || n > CELLS) return 1'b0;
    if (slot_used[n-1]) begin
      slot_used[n-1] = 1'b0;
      free_left++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic rssa_pkg::out_item_t allocator_step(rssa_pkg::in_item_t cmd);
    rssa_pkg::out_item_t r;
    int start;
    int slot;
    int pops;
    bit found;
    bit in_range;
    r = '0;
    found = 1'b0;
    in_range = cmd.number >= 1 && cmd.number <= CELLS;
    case (cmd.kind)
      rssa_pkg::KIND_ALLOC: begin
        if (free_left != 0) begin
          start = cmd.random_byte % CELLS;
          for (int i = 0; i < CELLS && !found; i++) begin
            slot = (start + i) % CELLS;
            if (!slot_used[slot]) begin
              slot_used[slot] = 1'b1;
              free_left--;
              r.granted_number = 7'(slot + 1);
              found = 1'b1;
            end
          end
        end
      end
      rssa_pkg::KIND_REINSTATE: begin
        if (!in_range) r.error_flag = 1'b1;
        else r.success = release_number(cmd.number);
      end
      rssa_pkg::KIND_PUSH: begin
        if (!in_range || held_depth >= DEPTH) begin
          r.error_flag = 1'b1;
        end else begin
          held[held_depth] = cmd.number;
          held_depth++;
          r.success = 1'b1;
        end
      end
      rssa_pkg::KIND_FLUSH: begin
        pops = cmd.pop_count;
        if (pops > held_depth) pops = held_depth;
        // pop order: newest first
        for (int i = 1; i <= pops; i++) void'(release_number(held[held_depth - i]));
        held_depth -= pops;
        r.success = 1'b1;
      end
      rssa_pkg::KIND_CLEAR: begin
        slot_used = '{default: 1'b0};
        free_left = CELLS;
        held_depth = 0;
        r.success = 1'b1;
      end
      default: begin
      end
    endcase
    r.free_count = 7'(free_left);
    r.stack_count = 7'(held_depth);
    return r;
  endfunction

  // all fields but the kind random; number mostly in range, pop count mostly modest
  function automatic rssa_pkg::in_item_t random_cmd(logic [2:0] k);
    rssa_pkg::in_item_t c;
    c.kind = k;
    c.random_byte = 8'($urandom_range(0, 255));
    c.number = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(1, CELLS));
    c.pop_count = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 20));
    return c;
  endfunction

  task automatic queue_cmd(logic [2:0] k, int rnd, int num, int fc);
    rssa_pkg::in_item_t c;
    c.kind = k;
    c.random_byte = 8'(rnd);
    c.number = 8'(num);
    c.pop_count = 7'(fc);
    cmd_backlog.push_back(c);
  endtask

  task automatic compare_field(string fname, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      errors++;
    end
  endtask

  task automatic build_directed();
    queue_cmd(rssa_pkg::KIND_ALLOC, 0, 0, 0);          // slot 0 -> 1
    queue_cmd(rssa_pkg::KIND_ALLOC, 255, 0, 0);        // 255 mod 64 -> 64
    queue_cmd(rssa_pkg::KIND_ALLOC, 63, 0, 0);         // wraps past 64, 1 -> 2
    queue_cmd(rssa_pkg::KIND_REINSTATE, 0, 0, 0);      // below range
    queue_cmd(rssa_pkg::KIND_REINSTATE, 0, CELLS + 1, 0);
    queue_cmd(rssa_pkg::KIND_REINSTATE, 255, 255, 127);
    queue_cmd(rssa_pkg::KIND_REINSTATE, 0, CELLS, 0);  // frees
    queue_cmd(rssa_pkg::KIND_REINSTATE, 0, CELLS, 0);  // already free
    queue_cmd(rssa_pkg::KIND_PUSH, 0, 0, 0);
    queue_cmd(rssa_pkg::KIND_PUSH, 0, 200, 0);
    queue_cmd(rssa_pkg::KIND_PUSH, 0, 1, 0);
    queue_cmd(rssa_pkg::KIND_PUSH, 0, 2, 0);
    queue_cmd(rssa_pkg::KIND_FLUSH, 0, 0, 127);        // clamped to two
    for (int k = rssa_pkg::KIND_CLEAR + 1; k <= KIND_TOP; k++) queue_cmd(3'(k), 170, 85, 85);
    queue_cmd(rssa_pkg::KIND_ALLOC, 128, 0, 0);
    queue_cmd(rssa_pkg::KIND_PUSH, 0, CELLS, 0);
    queue_cmd(rssa_pkg::KIND_FLUSH, 0, 0, 1);
    queue_cmd(rssa_pkg::KIND_CLEAR, 85, 170, 42);
    queue_cmd(rssa_pkg::KIND_FLUSH, 0, 0, 0);          // empty stack
    queue_cmd(rssa_pkg::KIND_FLUSH, 0, 0, 64);
  endtask

  task automatic build_random();
    int produced;
    int run;
    rssa_pkg::in_item_t c;
    produced = 0;
    // open with a full map and a full stack so the exhausted paths are hit early
    run = $urandom_range(CELLS, CELLS + 16);
    for (int i = 0; i < run; i++) cmd_backlog.push_back(random_cmd(rssa_pkg::KIND_ALLOC));
    run = $urandom_range(DEPTH, DEPTH + 8);
    for (int i = 0; i < run; i++) begin
      c = random_cmd(rssa_pkg::KIND_PUSH);
      c.number = 8'($urandom_range(1, CELLS));
      cmd_backlog.push_back(c);
    end
    produced = cmd_backlog.size();
    while (produced < RANDOM_TARGET) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: begin
          run = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 80) : $urandom_range(1, 16);
          for (int i = 0; i < run; i++) cmd_backlog.push_back(random_cmd(rssa_pkg::KIND_ALLOC));
          produced += run;
        end
        6, 7, 8: begin
          run = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 72) : $urandom_range(1, 20);
          for (int i = 0; i < run; i++) cmd_backlog.push_back(random_cmd(rssa_pkg::KIND_PUSH));
          produced += run;
        end
        9, 10, 11, 12: begin
          run = $urandom_range(1, 24);
          for (int i = 0; i < run; i++) begin
            cmd_backlog.push_back(random_cmd(rssa_pkg::KIND_REINSTATE));
          end
          produced += run;
        end
        13, 14, 15: begin
          cmd_backlog.push_back(random_cmd(rssa_pkg::KIND_FLUSH));
          produced++;
        end
        16: begin
          if ($urandom_range(0, 2) == 0) cmd_backlog.push_back(random_cmd(rssa_pkg::KIND_CLEAR));
          else cmd_backlog.push_back(random_cmd(rssa_pkg::KIND_FLUSH));
          produced++;
        end
        default: begin
          // noise: any kind, any field values
          run = $urandom_range(1, 6);
          for (int i = 0; i < run; i++) begin
            c.kind = 3'($urandom_range(0, KIND_TOP));
            c.random_byte = 8'($urandom_range(0, 255));
            c.number = 8'($urandom_range(0, 255));
            c.pop_count = 7'($urandom_range(0, 127));
            cmd_backlog.push_back(c);
            if (c.kind <= rssa_pkg::KIND_CLEAR) produced++;
          end
        end
      endcase
    end
  endtask

  // sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          in_data <= cmd_backlog.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches between modes, each held for a random-length phase
  always @(negedge clk) begin
    if (ready_phase_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_phase_left = $urandom_range(20, 300);
    end
    ready_phase_left--;
    ready_tick++;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (ready_tick % 24) >= 17;  // long periodic stall
    endcase
  end

  // monitor and prediction at the rising edge
  always @(posedge clk) begin
    rssa_pkg::out_item_t want;
    cycles++;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (awaited_outcomes.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %h", $time, out_data);
          errors++;
        end else begin
          want = awaited_outcomes.pop_front();
          compare_field("granted_number", want.granted_number, out_data.granted_number);
          compare_field("success", want.success, out_data.success);
          compare_field("error_flag", want.error_flag, out_data.error_flag);
          compare_field("free_count", want.free_count, out_data.free_count);
          compare_field("stack_count", want.stack_count, out_data.stack_count);
        end
      end
      if (in_valid && in_ready) awaited_outcomes.push_back(allocator_step(in_data));
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still awaited", $time, awaited_outcomes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    slot_used = '{default: 1'b0};
    free_left = CELLS;
    held_depth = 0;
    build_directed();
    build_random();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || awaited_outcomes.size() != 0) @(negedge clk);
    // catch any stray beat after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
